FILE: rtl/srte_pkg.sv
// Package for the sorted region table engine: request and status codes,
// record type, sequencer states and default sizes. No dependencies.
`default_nettype none
package srte_pkg;

  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned PageBytesDef    = 4096;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SPLIT  = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  localparam logic [1:0] BackingFile = 2'd1;

  // One stored record
  typedef struct packed {
    logic [63:0] start_addr;
    logic [63:0] end_addr;
    logic [63:0] offset;
    logic [2:0]  prot;
    logic [31:0] flags;
    logic [1:0]  backing;
    logic [15:0] map_id;
    logic [15:0] file_desc;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_SPLIT_R,
    S_MERGE_A,
    S_MERGE_B,
    S_MERGE_C,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/srte_req_if.sv
// Handshake channel interfaces for requests and results.
// Depends on no package; payload widths are fixed by the field list.
`default_nettype none
interface srte_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [6:0]  index;
  logic [6:0]  range_end_index;
  logic [63:0] cut_addr;
  logic [63:0] start_req;
  logic [63:0] end_req;
  logic [2:0]  prot;
  logic [31:0] map_flags;
  logic [1:0]  backing;
  logic [15:0] map_id;
  logic [15:0] file_desc;
  logic [63:0] backing_offset;
  modport source (output valid, req_type, index, range_end_index, cut_addr, start_req,
                  end_req, prot, map_flags, backing, map_id, file_desc, backing_offset,
                  input ready);
  modport sink (input valid, req_type, index, range_end_index, cut_addr, start_req,
                end_req, prot, map_flags, backing, map_id, file_desc, backing_offset,
                output ready);
endinterface

interface srte_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  live_count;
  logic [63:0] rd_start;
  logic [63:0] rd_end;
  logic [2:0]  rd_prot;
  logic [31:0] rd_flags;
  logic [1:0]  rd_backing;
  logic [15:0] rd_map_id;
  logic [15:0] rd_file_desc;
  logic [63:0] rd_backing_offset;
  logic        mergeable;
  modport source (output valid, status, live_count, rd_start, rd_end, rd_prot, rd_flags,
                  rd_backing, rd_map_id, rd_file_desc, rd_backing_offset, mergeable,
                  input ready);
  modport sink (input valid, status, live_count, rd_start, rd_end, rd_prot, rd_flags,
                rd_backing, rd_map_id, rd_file_desc, rd_backing_offset, mergeable,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/sorted_region_table_engine.sv
// Sorted region table engine top level: record memory and request sequencer.
// Depends on srte_pkg and the channel interfaces in srte_req_if.sv.
//
// The block keeps an ordered table of region records in one single-port-write,
// registered-read memory and serves one request at a time. After the lookup,
// every record that has to move takes a read and a write: an insert shifts
// the records from the index up, a split those above the index, and a remove
// shifts the records above the range down. The shift loop runs through the
// memory's single read port and single write port. The result is held in an
// output register until taken; no new request is taken meanwhile, and the
// next one can be accepted in the cycle after the result is taken.
// PAGE_BYTES must be a power of two.
`default_nettype none
module sorted_region_table_engine #(
  parameter int unsigned TABLE_ENTRIES = srte_pkg::TableEntriesDef,
  parameter int unsigned PAGE_BYTES    = srte_pkg::PageBytesDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  srte_req_if.sink    req_i,
  srte_rsp_if.source  rsp_o
);
  import srte_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned PW = $clog2(PAGE_BYTES);

  // Record memory
  rec_t mem_q [TABLE_ENTRIES];
  rec_t rd_data_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  rec_t          wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_data_q <= mem_q[rd_addr];
  end

  // Sequencer registers
  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] stop_q, stop_d;
  logic [CW-1:0] gap_q, gap_d;
  logic [1:0]  rtype_q, rtype_d;
  logic [CW-1:0] idx_q, idx_d, hi_q, hi_d;
  logic [63:0] saddr_q, saddr_d;
  rec_t        new_q, new_d;
  rec_t        rec_a_q, rec_a_d;
  rec_t        hold_q, hold_d;
  logic [63:0] sum_q, sum_d;
  logic        mval_q, mval_d;
  logic        ovalid_q, ovalid_d;
  logic [1:0]  ostat_q, ostat_d;
  rec_t        orec_q, orec_d;
  logic        omerge_q, omerge_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;  stop_q <= stop_d;  gap_q <= gap_d;
    rtype_q <= rtype_d;  idx_q <= idx_d;  hi_q <= hi_d;
    saddr_q <= saddr_d;  new_q <= new_d;  rec_a_q <= rec_a_d;
    hold_q <= hold_d;  sum_q <= sum_d;  mval_q <= mval_d;
    ostat_q <= ostat_d;  orec_q <= orec_d;  omerge_q <= omerge_d;
  end

  logic [CW-1:0] tbl_n;
  assign tbl_n = CW'(TABLE_ENTRIES);

  // Next state and datapath control
  always_comb begin
    state_d = state_q;  count_d = count_q;  ptr_d = ptr_q;  stop_d = stop_q;
    gap_d = gap_q;  rtype_d = rtype_q;  idx_d = idx_q;  hi_d = hi_q;
    saddr_d = saddr_q;  new_d = new_q;  rec_a_d = rec_a_q;  hold_d = hold_q;
    sum_d = sum_q;  mval_d = mval_q;  ovalid_d = ovalid_q;  ostat_d = ostat_q;
    orec_d = orec_q;  omerge_d = omerge_q;
    rd_addr = idx_q[AW-1:0];
    wr_addr = ptr_q[AW-1:0];
    wr_en = 1'b0;
    wr_data = hold_q;
    req_i.ready = 1'b0;
    if (ovalid_q && rsp_o.ready) ovalid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_i.ready = !ovalid_q;
        if (req_i.valid && !ovalid_q) begin
          rtype_d = req_i.req_type;
          idx_d   = CW'(req_i.index);
          hi_d    = CW'(req_i.range_end_index);
          saddr_d = req_i.cut_addr;
          new_d   = '{start_addr: req_i.start_req, end_addr: req_i.end_req,
                      offset: req_i.backing_offset, prot: req_i.prot,
                      flags: req_i.map_flags, backing: req_i.backing,
                      map_id: req_i.map_id, file_desc: req_i.file_desc};
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        ostat_d = ST_OK;  orec_d = '0;  omerge_d = 1'b0;
        case (rtype_q)
          REQ_INSERT: begin
            if (count_q >= tbl_n) begin
              ostat_d = ST_FULL;  state_d = S_DONE;
            end else if (idx_q > count_q) begin
              ostat_d = ST_INVALID;  state_d = S_DONE;
            end else begin
              ptr_d = count_q;  stop_d = idx_q;  gap_d = CW'(1);
              hold_d = new_q;
              state_d = S_SHIFT_RD;
            end
          end
          REQ_SPLIT: begin
            if (count_q >= tbl_n) begin
              ostat_d = ST_FULL;  state_d = S_DONE;
            end else if (idx_q >= count_q) begin
              ostat_d = ST_INVALID;  state_d = S_DONE;
            end else begin
              state_d = S_RD_A;
            end
          end
          REQ_REMOVE: begin
            if (idx_q < hi_q && hi_q <= count_q) begin
              gap_d = hi_q - idx_q;  ptr_d = hi_q;  stop_d = count_q;
              state_d = S_SHIFT_RD;
            end else begin
              state_d = S_DONE;
            end
          end
          default: begin
            if (idx_q >= count_q) begin
              ostat_d = ST_INVALID;  state_d = S_DONE;
            end else begin
              state_d = S_RD_A;
            end
          end
        endcase
      end
      // Memory read of record at idx issued; the data is used in S_RD_B
      S_RD_A: state_d = S_RD_B;
      S_RD_B: begin
        rec_a_d = rd_data_q;
        if (rtype_q == REQ_READ) begin
          orec_d  = rd_data_q;
          mval_d  = (idx_q + CW'(1)) < count_q;
          sum_d   = rd_data_q.end_addr - rd_data_q.start_addr;
          rd_addr = AW'(idx_q + CW'(1));
          state_d = S_MERGE_A;
        end else begin
          // Split: validate address, compute right-half offset
          if (!(rd_data_q.start_addr < saddr_q && saddr_q < rd_data_q.end_addr) ||
              (saddr_q[PW-1:0] != '0)) begin
            ostat_d = ST_INVALID;  state_d = S_DONE;
          end else begin
            sum_d = saddr_q - rd_data_q.start_addr;
            ptr_d = count_q;  stop_d = idx_q + CW'(1);  gap_d = CW'(1);
            state_d = S_SPLIT_R;
          end
        end
      end
      S_SPLIT_R: begin
        hold_d = rec_a_q;
        hold_d.start_addr = saddr_q;
        if (rec_a_q.backing == BackingFile) hold_d.offset = rec_a_q.offset + sum_q;
        // write left half now
        wr_en = 1'b1;  wr_addr = idx_q[AW-1:0];
        wr_data = rec_a_q;  wr_data.end_addr = saddr_q;
        state_d = S_SHIFT_RD;
      end
      // Shift loop: insert/split move up until ptr == stop, remove moves down
      S_SHIFT_RD: begin
        if (rtype_q == REQ_REMOVE) begin
          if (ptr_q >= stop_q) begin
            count_d = count_q - gap_q;  state_d = S_DONE;
          end else begin
            rd_addr = ptr_q[AW-1:0];  state_d = S_SHIFT_WR;
          end
        end else begin
          if (ptr_q == stop_q) begin
            state_d = S_WRITE;
          end else begin
            rd_addr = AW'(ptr_q - CW'(1));  state_d = S_SHIFT_WR;
          end
        end
      end
      S_SHIFT_WR: begin
        wr_en = 1'b1;  wr_data = rd_data_q;
        if (rtype_q == REQ_REMOVE) begin
          wr_addr = AW'(ptr_q - gap_q);  ptr_d = ptr_q + CW'(1);
        end else begin
          wr_addr = ptr_q[AW-1:0];  ptr_d = ptr_q - CW'(1);
        end
        state_d = S_SHIFT_RD;
      end
      S_WRITE: begin
        wr_en = 1'b1;  wr_addr = stop_q[AW-1:0];  wr_data = hold_q;
        count_d = count_q + CW'(1);
        state_d = S_DONE;
      end
      // Merge check: keep the next record on the read port, capture it, compare
      S_MERGE_A: begin
        rd_addr = AW'(idx_q + CW'(1));
        sum_d = rec_a_q.offset + sum_q;
        state_d = S_MERGE_B;
      end
      S_MERGE_B: begin
        hold_d = rd_data_q;
        state_d = S_MERGE_C;
      end
      S_MERGE_C: begin
        omerge_d = mval_q && (rec_a_q.end_addr == hold_q.start_addr) &&
                   (rec_a_q.prot == hold_q.prot) && (rec_a_q.flags == hold_q.flags) &&
                   (rec_a_q.backing == hold_q.backing) &&
                   (rec_a_q.map_id == hold_q.map_id) &&
                   ((rec_a_q.backing != BackingFile) ||
                    ((rec_a_q.file_desc == hold_q.file_desc) &&
                     (sum_q == hold_q.offset)));
        state_d = S_DONE;
      end
      S_DONE: begin
        ovalid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result register to port
  assign rsp_o.valid             = ovalid_q;
  assign rsp_o.status            = ostat_q;
  assign rsp_o.live_count        = 7'(count_q);
  assign rsp_o.rd_start          = orec_q.start_addr;
  assign rsp_o.rd_end            = orec_q.end_addr;
  assign rsp_o.rd_prot           = orec_q.prot;
  assign rsp_o.rd_flags          = orec_q.flags;
  assign rsp_o.rd_backing        = orec_q.backing;
  assign rsp_o.rd_map_id         = orec_q.map_id;
  assign rsp_o.rd_file_desc      = orec_q.file_desc;
  assign rsp_o.rd_backing_offset = orec_q.offset;
  assign rsp_o.mergeable         = omerge_q;

endmodule
`default_nettype wire
